FILE: design/tft_pkg.sv
// Shared types, constants and codes for the text field tokenizer.
`timescale 1ns / 1ps

package tft_pkg;

    // Field widths
    localparam int DATA_BITS     = 8;
    localparam int COLUMN_BITS   = 12;
    localparam int ROW_BITS      = 24;
    localparam int MAX_ROWS_BITS = 24;
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 4;

    // Most results per input item
    localparam int MAX_RESULTS = 3;
    localparam int COUNT_BITS  = $clog2(MAX_RESULTS + 1);

    // Default depth of the queue between front and back end
    localparam int QUEUE_DEPTH = 4;

    // Fixed bytes
    localparam logic [DATA_BITS-1:0] ESCAPE_BYTE   = 8'h5C;
    localparam logic [DATA_BITS-1:0] NEWLINE_BYTE  = 8'h0A;
    localparam logic [DATA_BITS-1:0] SPACE_BYTE    = 8'h20;
    localparam logic [DATA_BITS-1:0] TAB_BYTE      = 8'h09;
    localparam logic [DATA_BITS-1:0] CR_BYTE       = 8'h0D;
    localparam logic [DATA_BITS-1:0] QUOTE_RESET   = 8'h22;
    localparam logic [DATA_BITS-1:0] COMMENT_RESET = 8'h23;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_CHAR      = 2'd0,
        KIND_FIELD_END = 2'd1,
        KIND_ROW_END   = 2'd2
    } tft_kind_t;

    // Register indexes (word address)
    typedef enum logic [1:0] {
        REG_QUOTE    = 2'd0,
        REG_COMMENT  = 2'd1,
        REG_MAX_ROWS = 2'd2
    } tft_reg_idx_t;

    // Input item
    typedef struct packed {
        logic [DATA_BITS-1:0] data_byte;
        logic                 end_of_input;
    } tft_item_t;

    // Result item
    typedef struct packed {
        tft_kind_t              kind;
        logic [DATA_BITS-1:0]   out_byte;
        logic [COLUMN_BITS-1:0] column_index;
        logic [ROW_BITS-1:0]    row_index;
        logic                   last_result;
    } tft_result_t;

    // All results caused by one input item
    typedef struct packed {
        logic [COUNT_BITS-1:0]              count;
        tft_result_t [MAX_RESULTS-1:0]      res;
    } tft_bundle_t;

    // Configuration seen by the front end
    typedef struct packed {
        logic [DATA_BITS-1:0]     quote_char;
        logic [DATA_BITS-1:0]     comment_char;
        logic [MAX_ROWS_BITS-1:0] max_rows;
    } tft_cfg_t;

    // Tokenizer state
    typedef struct packed {
        logic                   at_line_start;
        logic                   in_comment_line;
        logic                   in_quotes;
        logic                   in_field;
        logic                   escape_pending;
        logic                   row_open;
        logic                   stopped;
        logic [COLUMN_BITS-1:0] column_count;
        logic [ROW_BITS-1:0]    row_count;
    } tft_state_t;

    localparam tft_state_t STATE_RESET = '{
        at_line_start:   1'b1,
        in_comment_line: 1'b0,
        in_quotes:       1'b0,
        in_field:        1'b0,
        escape_pending:  1'b0,
        row_open:        1'b0,
        stopped:         1'b0,
        column_count:    '0,
        row_count:       '0
    };

endpackage

FILE: design/tft_regs.sv
// Configuration registers behind an APB-style port.
`timescale 1ns / 1ps

module tft_regs
    import tft_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    output tft_cfg_t                 cfg
);

    tft_cfg_t     cfg_reg;
    tft_cfg_t     cfg_next;
    tft_reg_idx_t reg_idx;
    logic         wr_en;

    assign pready  = 1'b1;
    assign reg_idx = tft_reg_idx_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    // Decode a write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_QUOTE:    cfg_next.quote_char   = pwdata[DATA_BITS-1:0];
                REG_COMMENT:  cfg_next.comment_char = pwdata[DATA_BITS-1:0];
                REG_MAX_ROWS: cfg_next.max_rows     = pwdata[MAX_ROWS_BITS-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.quote_char   <= QUOTE_RESET;
            cfg_reg.comment_char <= COMMENT_RESET;
            cfg_reg.max_rows     <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back
    always_comb
    begin
        unique case (reg_idx)
            REG_QUOTE:    prdata = APB_DATA_BITS'(cfg_reg.quote_char);
            REG_COMMENT:  prdata = APB_DATA_BITS'(cfg_reg.comment_char);
            REG_MAX_ROWS: prdata = APB_DATA_BITS'(cfg_reg.max_rows);
            default:      prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

FILE: design/tft_front.sv
// Front end: a byte per cycle unless full; tracks line state, forms result bursts.
`timescale 1ns / 1ps

module tft_front
    import tft_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  tft_item_t   item,
    input  tft_cfg_t    cfg,
    output logic        q_push,
    output tft_bundle_t q_bundle,
    input  logic        q_full
);

    tft_state_t state_reg;
    tft_state_t state_next;
    logic       accept;

    function automatic tft_result_t make_result(
        input tft_kind_t              kind,
        input logic [DATA_BITS-1:0]   data,
        input logic [COLUMN_BITS-1:0] col,
        input logic [ROW_BITS-1:0]    row
    );
        tft_result_t r;
        r.kind         = kind;
        r.out_byte     = data;
        r.column_index = col;
        r.row_index    = row;
        r.last_result  = 1'b0;
        return r;
    endfunction

    assign full   = q_full;
    assign accept = push && !full;

    // Work one byte through the tokenizer rules
    always_comb
    begin
        tft_state_t                    st;
        tft_result_t [MAX_RESULTS-1:0] res;
        logic [COUNT_BITS-1:0]         n;
        logic [DATA_BITS-1:0]          b;
        logic                          ws;
        logic                          nl;
        logic                          skip;
        logic                          do_collect;
        logic                          do_close_field;
        logic                          do_close_row;
        logic                          limit_hit;

        st             = state_reg;
        res            = '0;
        n              = '0;
        b              = item.data_byte;
        ws             = (b == SPACE_BYTE) || ((b >= TAB_BYTE) && (b <= CR_BYTE));
        nl             = (b == NEWLINE_BYTE);
        skip           = 1'b0;
        do_collect     = 1'b0;
        do_close_field = 1'b0;
        do_close_row   = 1'b0;
        limit_hit      = (cfg.max_rows != '0) && (state_reg.row_count >= cfg.max_rows);

        if (!st.stopped)
        begin
            // Line start: drop leading whitespace, spot comment lines
            if (st.in_comment_line)
            begin
                skip = 1'b1;
                if (nl)
                begin
                    st.in_comment_line = 1'b0;
                    st.at_line_start   = 1'b1;
                end
            end
            else if (st.at_line_start)
            begin
                if (ws)
                begin
                    skip = 1'b1;
                end
                else if (b == cfg.comment_char)
                begin
                    skip               = 1'b1;
                    st.in_comment_line = 1'b1;
                    st.at_line_start   = 1'b0;
                end
                else
                begin
                    st.at_line_start = 1'b0;
                end
            end

            if (!skip)
            begin
                // Classify: escape first, then whitespace, then quote
                if (st.escape_pending)
                begin
                    st.escape_pending = 1'b0;
                    do_collect        = 1'b1;
                end
                else if (b == ESCAPE_BYTE)
                begin
                    st.escape_pending = 1'b1;
                end
                else if (ws)
                begin
                    if (st.in_quotes)
                    begin
                        do_collect = 1'b1;
                    end
                    else
                    begin
                        do_close_field = 1'b1;
                        do_close_row   = nl;
                    end
                end
                else if (b == cfg.quote_char)
                begin
                    st.in_quotes = !st.in_quotes;
                end
                else
                begin
                    do_collect = 1'b1;
                end

                // Store a field byte, opening field and row as needed
                if (do_collect)
                begin
                    if (!st.in_field && !st.row_open && limit_hit)
                    begin
                        st.stopped = 1'b1;
                    end
                    else
                    begin
                        st.row_open = 1'b1;
                        st.in_field = 1'b1;
                        if (n != COUNT_BITS'(MAX_RESULTS))
                        begin
                            res[n] = make_result(KIND_CHAR, b, st.column_count, st.row_count);
                            n      = n + 1'b1;
                        end
                    end
                end

                // Close the field on unquoted whitespace
                if (do_close_field && st.in_field)
                begin
                    if (n != COUNT_BITS'(MAX_RESULTS))
                    begin
                        res[n] = make_result(KIND_FIELD_END, '0, st.column_count,
                                             st.row_count);
                        n      = n + 1'b1;
                    end
                    if (st.column_count != '1)
                        st.column_count = st.column_count + 1'b1;
                    st.in_field = 1'b0;
                end

                // Close the row on newline
                if (do_close_row && st.row_open)
                begin
                    if (n != COUNT_BITS'(MAX_RESULTS))
                    begin
                        res[n] = make_result(KIND_ROW_END, '0, st.column_count,
                                             st.row_count);
                        n      = n + 1'b1;
                    end
                    if (st.row_count != '1)
                        st.row_count = st.row_count + 1'b1;
                    st.column_count = '0;
                    st.row_open     = 1'b0;
                end

                if (nl && !st.stopped)
                    st.at_line_start = 1'b1;
            end
        end

        // End of input: close what is open, then return to reset state
        if (item.end_of_input)
        begin
            if (!st.stopped)
            begin
                if (st.in_field)
                begin
                    if (n != COUNT_BITS'(MAX_RESULTS))
                    begin
                        res[n] = make_result(KIND_FIELD_END, '0, st.column_count,
                                             st.row_count);
                        n      = n + 1'b1;
                    end
                    if (st.column_count != '1)
                        st.column_count = st.column_count + 1'b1;
                    st.in_field = 1'b0;
                end
                if (st.row_open)
                begin
                    if (n != COUNT_BITS'(MAX_RESULTS))
                    begin
                        res[n] = make_result(KIND_ROW_END, '0, st.column_count,
                                             st.row_count);
                        n      = n + 1'b1;
                    end
                end
            end
            st = STATE_RESET;
        end

        // Flag the final result of the burst
        if (n != '0)
            res[n - 1'b1].last_result = 1'b1;

        state_next     = st;
        q_bundle.count = n;
        q_bundle.res   = res;
        q_push         = accept && (n != '0);
    end

    // Advance the state on an accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= STATE_RESET;
        else if (accept)
            state_reg <= state_next;
    end

endmodule

FILE: design/tft_queue.sv
// Short queue of result bursts between the front and back end.
`timescale 1ns / 1ps

module tft_queue
    import tft_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  tft_bundle_t wr_data,
    output logic        wr_full,
    input  logic        rd_en,
    output tft_bundle_t rd_data,
    output logic        rd_empty
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    tft_bundle_t         slots_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;
    logic                do_wr;
    logic                do_rd;

    assign wr_full  = (count_reg == CNT_BITS'(DEPTH));
    assign rd_empty = (count_reg == '0);
    assign do_wr    = wr_en && !wr_full;
    assign do_rd    = rd_en && !rd_empty;
    assign rd_data  = slots_reg[rd_ptr_reg];

    // Advance pointers with wrap
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store a burst
    always_ff @(posedge clk)
    begin
        if (do_wr)
            slots_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

FILE: design/tft_back.sv
// Back end: unpacks result bursts and presents one result item at a time.
`timescale 1ns / 1ps

module tft_back
    import tft_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  tft_bundle_t q_bundle,
    input  logic        q_empty,
    output logic        q_pop,
    output logic        empty,
    input  logic        pop,
    output tft_result_t result
);

    tft_result_t [MAX_RESULTS-1:0] slots_reg;
    tft_result_t [MAX_RESULTS-1:0] slots_next;
    logic [COUNT_BITS-1:0]         count_reg;
    logic [COUNT_BITS-1:0]         count_next;
    logic                          take;
    logic                          drained;

    assign empty   = (count_reg == '0);
    assign result  = slots_reg[0];
    assign take    = pop && !empty;
    assign drained = empty || (take && (count_reg == COUNT_BITS'(1)));
    assign q_pop   = drained && !q_empty;

    // Refill from the queue or shift to the next result
    always_comb
    begin
        slots_next = slots_reg;
        count_next = count_reg;
        if (q_pop)
        begin
            slots_next = q_bundle.res;
            count_next = q_bundle.count;
        end
        else if (take)
        begin
            for (int i = 0; i < MAX_RESULTS - 1; i++)
                slots_next[i] = slots_reg[i + 1];
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        slots_reg <= slots_next;
    end

endmodule

FILE: design/text_field_tokenizer_core.sv
// Top level of the text field tokenizer: registers, front end, queue, back end.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-------------------------------------
//  item     | in        | push / full        | data_byte, end_of_input
//  result   | out       | pop / empty        | kind, out_byte, column_index,
//           |           |                    | row_index, last_result
//  config   | in        | psel/penable/pready| quote_char, comment_char, max_rows
//
//  One byte is taken per cycle while the burst queue has room; each byte yields
//  zero to three result items, and the back end delivers one result per cycle
//  while pop is high and results wait. The results of a byte pass through the
//  burst queue and then the back-end result slots before the result port.
//  Reset (rst_n low) clears tokenizer state and queues; registers return to defaults.
//  A stall on pop fills the burst queue; full rises only when the queue is full.
`timescale 1ns / 1ps

module text_field_tokenizer_core
    import tft_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    output logic                     full,
    input  tft_item_t                item,
    output logic                     empty,
    input  logic                     pop,
    output tft_result_t              result,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    tft_cfg_t    cfg;
    logic        q_push;
    logic        q_full;
    tft_bundle_t q_wr_bundle;
    logic        q_pop;
    logic        q_empty;
    tft_bundle_t q_rd_bundle;

    tft_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tft_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .cfg      (cfg),
        .q_push   (q_push),
        .q_bundle (q_wr_bundle),
        .q_full   (q_full)
    );

    tft_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_push),
        .wr_data  (q_wr_bundle),
        .wr_full  (q_full),
        .rd_en    (q_pop),
        .rd_data  (q_rd_bundle),
        .rd_empty (q_empty)
    );

    tft_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_bundle (q_rd_bundle),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .empty    (empty),
        .pop      (pop),
        .result   (result)
    );

endmodule

FILE: design/tft_checker.sv
// Port-level checks for the text field tokenizer, bound to the top level.
`timescale 1ns / 1ps

module tft_checker
    import tft_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input tft_result_t result
);

    // Hold a waiting result until it is taken
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("result changed while waiting");

    // Zero the byte on marker items
    a_marker_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.kind != KIND_CHAR) |-> (result.out_byte == '0))
        else $error("marker item carries a byte");

    // Row end always closes its burst
    a_row_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.kind == KIND_ROW_END) |-> result.last_result)
        else $error("row end not last in burst");

    // A field end that is not last is followed at once by a row end
    a_field_then_row: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && result.kind == KIND_FIELD_END && !result.last_result)
        |=> (!empty && result.kind == KIND_ROW_END))
        else $error("field end not followed by row end");

endmodule

bind text_field_tokenizer_core tft_checker u_chk (.*);

FILE: dv/testbench.sv
// Self-checking testbench for the text field tokenizer core.
`timescale 1ns / 1ps

module testbench
    import tft_pkg::*;
();

    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE_TICKS = 8;

    logic                     clk;
    logic                     rst_n;
    logic                     push;
    logic                     full;
    tft_item_t                item;
    logic                     empty;
    logic                     pop;
    tft_result_t              result;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    text_field_tokenizer_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .item    (item),
        .empty   (empty),
        .pop     (pop),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Register mirror
    logic [DATA_BITS-1:0]     cfg_quote;
    logic [DATA_BITS-1:0]     cfg_comment;
    logic [MAX_ROWS_BITS-1:0] cfg_max_rows;

    // Tokenizer state mirror
    logic                   at_line_start;
    logic                   in_comment_line;
    logic                   in_quotes;
    logic                   in_field;
    logic                   escape_pending;
    logic                   row_open;
    logic                   stopped;
    logic [COLUMN_BITS-1:0] column_count;
    logic [ROW_BITS-1:0]    row_count;

    tft_result_t byte_tokens[$];
    tft_result_t expected_tokens[$];

    int  mismatches;
    int  burst_left;
    bit  hold_off_request;

    // Clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic void flag_mismatch(string what);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH: %s", what);
    endfunction

    // ---------------------------------------------------------------
    // Tokenizer predictor
    // ---------------------------------------------------------------
    function automatic void clear_tokenizer();
        at_line_start   = 1'b1;
        in_comment_line = 1'b0;
        in_quotes       = 1'b0;
        in_field        = 1'b0;
        escape_pending  = 1'b0;
        row_open        = 1'b0;
        stopped         = 1'b0;
        column_count    = '0;
        row_count       = '0;
    endfunction

    function automatic bit is_blank(logic [DATA_BITS-1:0] b);
        return b == SPACE_BYTE || (b >= TAB_BYTE && b <= CR_BYTE);
    endfunction

    function automatic void add_token(tft_kind_t kind, logic [DATA_BITS-1:0] b,
                                      logic [COLUMN_BITS-1:0] col);
        tft_result_t r;
        r.kind         = kind;
        r.out_byte     = b;
        r.column_index = col;
        r.row_index    = row_count;
        r.last_result  = 1'b0;
        byte_tokens.push_back(r);
    endfunction

    function automatic void end_field();
        if (!in_field)
            return;
        add_token(KIND_FIELD_END, '0, column_count);
        if (column_count != '1)
            column_count++;
        in_field = 1'b0;
    endfunction

    function automatic void end_row();
        if (!row_open)
            return;
        add_token(KIND_ROW_END, '0, column_count);
        if (row_count != '1)
            row_count++;
        column_count = '0;
        row_open     = 1'b0;
    endfunction

    function automatic void store_char(logic [DATA_BITS-1:0] b);
        if (!in_field)
        begin
            if (!row_open)
            begin
                // Row limit reached: drop everything up to end of input
                if (cfg_max_rows != 0 && row_count >= ROW_BITS'(cfg_max_rows))
                begin
                    stopped = 1'b1;
                    return;
                end
                row_open = 1'b1;
            end
            in_field = 1'b1;
        end
        add_token(KIND_CHAR, b, column_count);
    endfunction

    function automatic void scan_byte(logic [DATA_BITS-1:0] b);
        if (in_comment_line)
        begin
            if (b == NEWLINE_BYTE)
            begin
                in_comment_line = 1'b0;
                at_line_start   = 1'b1;
            end
            return;
        end
        // Skip leading whitespace and detect comment lines
        if (at_line_start)
        begin
            if (is_blank(b))
                return;
            if (b == cfg_comment)
            begin
                in_comment_line = 1'b1;
                at_line_start   = 1'b0;
                return;
            end
            at_line_start = 1'b0;
        end
        if (escape_pending)
        begin
            escape_pending = 1'b0;
            store_char(b);
        end
        else if (b == ESCAPE_BYTE)
            escape_pending = 1'b1;
        else if (is_blank(b))
        begin
            if (in_quotes)
                store_char(b);
            else
            begin
                end_field();
                if (b == NEWLINE_BYTE)
                    end_row();
            end
        end
        else if (b == cfg_quote)
            in_quotes = !in_quotes;
        else
            store_char(b);
        if (b == NEWLINE_BYTE && !stopped)
            at_line_start = 1'b1;
    endfunction

    // Work out the results of one accepted byte and queue them
    function automatic void tokenize_byte(tft_item_t it);
        byte_tokens.delete();
        if (!stopped)
            scan_byte(it.data_byte);
        if (it.end_of_input)
        begin
            if (!stopped)
            begin
                end_field();
                end_row();
            end
            clear_tokenizer();
        end
        if (byte_tokens.size() > 0)
            byte_tokens[byte_tokens.size() - 1].last_result = 1'b1;
        foreach (byte_tokens[i])
            expected_tokens.push_back(byte_tokens[i]);
    endfunction

    // ---------------------------------------------------------------
    // Byte sender: bursts with random gaps
    // ---------------------------------------------------------------
    task automatic send_byte(logic [DATA_BITS-1:0] b, logic eoi);
        tft_item_t it;
        int        gap;
        it.data_byte    = b;
        it.end_of_input = eoi;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        push <= 1'b1;
        item <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        tokenize_byte(it);
        burst_left--;
    endtask

    task automatic send_text(string s, logic eoi_last);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], eoi_last && i == s.len() - 1);
    endtask

    // Mostly text-like bytes, with some raw noise
    function automatic logic [DATA_BITS-1:0] pick_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return 8'h61 + 8'($urandom_range(0, 25));
        else if (r < 45)
            return SPACE_BYTE;
        else if (r < 50)
            return TAB_BYTE;
        else if (r < 62)
            return NEWLINE_BYTE;
        else if (r < 68)
            return cfg_quote;
        else if (r < 72)
            return cfg_comment;
        else if (r < 77)
            return ESCAPE_BYTE;
        else if (r < 80)
            return 8'($urandom_range(11, 13));
        else
            return 8'($urandom_range(0, 255));
    endfunction

    // Drop push, wait for every expected result, then let the pipeline settle
    task automatic drain_results();
        push <= 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // Register access
    // ---------------------------------------------------------------
    task automatic write_reg(tft_reg_idx_t idx, logic [APB_DATA_BITS-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_QUOTE:    cfg_quote    = value[DATA_BITS-1:0];
            REG_COMMENT:  cfg_comment  = value[DATA_BITS-1:0];
            REG_MAX_ROWS: cfg_max_rows = value[MAX_ROWS_BITS-1:0];
            default:      ;
        endcase
        @(posedge clk);
    endtask

    task automatic check_reg(tft_reg_idx_t idx);
        logic [APB_DATA_BITS-1:0] want;
        case (idx)
            REG_QUOTE:    want = APB_DATA_BITS'(cfg_quote);
            REG_COMMENT:  want = APB_DATA_BITS'(cfg_comment);
            default:      want = APB_DATA_BITS'(cfg_max_rows);
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== want)
            flag_mismatch($sformatf("register %s read %h, expected %h",
                                    idx.name(), prdata, want));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(logic [DATA_BITS-1:0] q, logic [DATA_BITS-1:0] c,
                              logic [MAX_ROWS_BITS-1:0] m);
        drain_results();
        write_reg(REG_QUOTE, APB_DATA_BITS'(q));
        write_reg(REG_COMMENT, APB_DATA_BITS'(c));
        write_reg(REG_MAX_ROWS, APB_DATA_BITS'(m));
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_registers();
        drain_results();
        check_reg(REG_QUOTE);
        check_reg(REG_COMMENT);
        check_reg(REG_MAX_ROWS);
        write_reg(REG_QUOTE, '1);
        write_reg(REG_COMMENT, '0);
        write_reg(REG_MAX_ROWS, '1);
        check_reg(REG_QUOTE);
        check_reg(REG_COMMENT);
        check_reg(REG_MAX_ROWS);
        set_config(QUOTE_RESET, COMMENT_RESET, '0);
        check_reg(REG_QUOTE);
        check_reg(REG_COMMENT);
        check_reg(REG_MAX_ROWS);
    endtask

    // Comment line, leading blanks, quoted blank, escaped newline, empty quotes,
    // CR, blank line, extreme bytes, final byte without newline, open quote
    // and pending escape at end of input
    task automatic test_directed();
        send_text("#c\n \tx\"y z\"\\\n\"\" q", 1'b0);
        send_byte(CR_BYTE, 1'b0);
        send_text("\n\n", 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_text("\"ab", 1'b0);
        send_byte(ESCAPE_BYTE, 1'b1);
    endtask

    task automatic test_row_limit();
        set_config(QUOTE_RESET, COMMENT_RESET, 24'd1);
        send_text("a b\nc d\ne\n", 1'b1);
        send_text("f\n", 1'b1);
        set_config(QUOTE_RESET, COMMENT_RESET, 24'd2);
        send_text("g\n\n#x\nh i\nj\n", 1'b1);
    endtask

    task automatic random_text(int n_items);
        logic eoi;
        for (int i = 0; i < n_items; i++)
        begin
            eoi = (i == n_items - 1) || ($urandom_range(0, 59) == 0);
            send_byte(pick_byte(), eoi);
        end
    endtask

    task automatic test_random_settings();
        set_config(QUOTE_RESET, COMMENT_RESET, '0);
        random_text(80);
        set_config(8'h00, 8'hFF, 24'd1);
        random_text(80);
        set_config(8'hFF, 8'h00, '1);
        random_text(80);
        set_config(ESCAPE_BYTE, SPACE_BYTE, 24'd3);
        random_text(80);
        set_config(TAB_BYTE, 8'h61, 24'd2);
        random_text(80);
    endtask

    // Receiver holds off while bytes keep coming, so the input stalls
    task automatic test_backpressure();
        set_config(QUOTE_RESET, COMMENT_RESET, '0);
        hold_off_request = 1'b1;
        random_text(40);
    endtask

    // ---------------------------------------------------------------
    // Receiver: random stalls, quiet stretches, one long hold-off
    // ---------------------------------------------------------------
    initial
    begin : receiver
        int  stall_left;
        int  tick;
        bit  quiet;
        stall_left = 0;
        tick       = 0;
        quiet      = 1'b0;
        pop <= 1'b0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (tick % 256 == 0)
                quiet = ($urandom_range(0, 2) == 0);
            if (hold_off_request)
            begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off_request = 1'b0;
            end
            else if (stall_left != 0)
            begin
                pop <= 1'b0;
                stall_left--;
            end
            else
            begin
                pop <= 1'b1;
                if (!quiet && $urandom_range(0, 5) == 0)
                    stall_left = $urandom_range(1, 6);
            end
        end
    end

    // ---------------------------------------------------------------
    // Result checker
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        tft_result_t want;
        if (rst_n && pop && !empty)
        begin
            if (expected_tokens.size() == 0)
                flag_mismatch($sformatf("unexpected result %p", result));
            else
            begin
                want = expected_tokens.pop_front();
                if (result.kind !== want.kind || result.out_byte !== want.out_byte ||
                    result.column_index !== want.column_index ||
                    result.row_index !== want.row_index ||
                    result.last_result !== want.last_result)
                    flag_mismatch($sformatf(
                        {"expected kind %0d byte %h col %0d row %0d last %b, ",
                         "got kind %0d byte %h col %0d row %0d last %b"},
                        want.kind, want.out_byte, want.column_index, want.row_index,
                        want.last_result, result.kind, result.out_byte,
                        result.column_index, result.row_index, result.last_result));
            end
        end
    end

    // Run limit
    initial
    begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin
        mismatches       = 0;
        burst_left       = 0;
        hold_off_request = 1'b0;
        cfg_quote        = QUOTE_RESET;
        cfg_comment      = COMMENT_RESET;
        cfg_max_rows     = '0;
        clear_tokenizer();
        rst_n   <= 1'b0;
        push    <= 1'b0;
        item    <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_directed();
        test_registers();
        test_row_limit();
        test_random_settings();
        test_backpressure();

        drain_results();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
